>>> src/mts_pkg.sv
// shared types and constants for the min tracking stack
package mts_pkg;

  localparam int DEPTH  = 64;
  localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int DATA_W = 32;

  localparam logic signed [DATA_W-1:0] MAX_VAL = {1'b0, {(DATA_W-1){1'b1}}};

  typedef enum logic {
    FUNC_PUSH = 1'b0,
    FUNC_POP  = 1'b1
  } func_e;

  typedef struct packed {
    logic signed [DATA_W-1:0] min_val;
    logic signed [DATA_W-1:0] value;
  } entry_t;

  localparam int ENTRY_W = $bits(entry_t);

endpackage

>>> src/mts_ram.sv
// simple dual port synchronous ram with registered read data
module mts_ram #(
  parameter int Depth = 64,
  parameter int Width = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/min_tracking_stack.sv
// min tracking stack top level: entry memory, cached top entry and result register
//
//  channel  | dir | tdata                                   | tuser
//  s_axis   | in  | push_value[31:0]                        | func
//  m_axis   | out | popped_value, current_min, empty, ovf   | popped_valid
//
// a push, or a pop on an empty stack, is finished in ST_IDLE; a pop that removes an
// entry goes on to ST_POP, where the new top entry, read from the entry memory
// during the pop, is loaded into the cached top entry unless the stack is now empty
// reset clears the entry count and the result register, memory is not cleared
// a result waits in the output register; the next request is taken while it drains
module min_tracking_stack (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [31:0] push_value
  input  logic        s_axis_tuser_i,   // [0] func
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [71:0] m_axis_tdata_o,   // [31:0] popped_value, [63:32] current_min,
                                        // [64] is_empty, [65] overflow, rest zero
  output logic        m_axis_tuser_o    // [0] popped_valid
);

  typedef enum logic {
    ST_IDLE,
    ST_POP
  } state_e;

  state_e                            state_q;
  logic [mts_pkg::CNT_W-1:0]         count_q;
  mts_pkg::entry_t                   top_q;
  logic                              out_valid_q;
  logic signed [mts_pkg::DATA_W-1:0] out_popped_q;
  logic                              out_popped_valid_q;
  logic signed [mts_pkg::DATA_W-1:0] out_min_q;
  logic                              out_empty_q;
  logic                              out_ovf_q;

  logic                              accept;
  logic                              is_pop;
  logic                              full;
  logic                              empty;
  logic signed [mts_pkg::DATA_W-1:0] push_val;
  logic signed [mts_pkg::DATA_W-1:0] below_min;
  logic signed [mts_pkg::DATA_W-1:0] new_min;
  logic                              push_ok;
  logic                              pop_ok;
  logic [mts_pkg::CNT_W-1:0]         cnt_m2;
  mts_pkg::entry_t                   wr_entry;
  mts_pkg::entry_t                   rd_entry;
  logic [mts_pkg::ENTRY_W-1:0]       rd_bits;

  assign s_axis_tready_o = (state_q == ST_IDLE) && (!out_valid_q || m_axis_tready_i);
  assign accept   = s_axis_tvalid_i && s_axis_tready_o;
  assign is_pop   = (mts_pkg::func_e'(s_axis_tuser_i) == mts_pkg::FUNC_POP);
  assign full     = (count_q == mts_pkg::CNT_W'(mts_pkg::DEPTH));
  assign empty    = (count_q == '0);
  assign push_val = s_axis_tdata_i;
  assign below_min = empty ? mts_pkg::MAX_VAL : top_q.min_val;
  assign new_min   = (push_val < below_min) ? push_val : below_min;
  assign push_ok  = accept && !is_pop && !full;
  assign pop_ok   = accept && is_pop && !empty;
  assign cnt_m2   = count_q - mts_pkg::CNT_W'(2);

  assign wr_entry.min_val = new_min;
  assign wr_entry.value   = push_val;
  assign rd_entry         = mts_pkg::entry_t'(rd_bits);

  mts_ram #(
    .Depth (mts_pkg::DEPTH),
    .Width (mts_pkg::ENTRY_W)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (push_ok),
    .waddr_i (count_q[mts_pkg::ADDR_W-1:0]),
    .wdata_i (wr_entry),
    .re_i    (pop_ok),
    .raddr_i (cnt_m2[mts_pkg::ADDR_W-1:0]),
    .rdata_o (rd_bits)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q            <= ST_IDLE;
      count_q            <= '0;
      out_valid_q        <= 1'b0;
      top_q              <= '0;
      out_popped_q       <= '0;
      out_popped_valid_q <= 1'b0;
      out_min_q          <= mts_pkg::MAX_VAL;
      out_empty_q        <= 1'b1;
      out_ovf_q          <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (accept) begin
            if (!is_pop) begin
              out_popped_q       <= '0;
              out_popped_valid_q <= 1'b0;
              out_empty_q        <= 1'b0;
              out_valid_q        <= 1'b1;
              out_ovf_q          <= full;
              if (full) begin
                out_min_q <= top_q.min_val;
              end else begin
                count_q   <= count_q + mts_pkg::CNT_W'(1);
                top_q     <= wr_entry;
                out_min_q <= new_min;
              end
            end else if (empty) begin
              out_popped_q       <= '0;
              out_popped_valid_q <= 1'b0;
              out_min_q          <= mts_pkg::MAX_VAL;
              out_empty_q        <= 1'b1;
              out_ovf_q          <= 1'b0;
              out_valid_q        <= 1'b1;
            end else begin
              count_q            <= count_q - mts_pkg::CNT_W'(1);
              out_popped_q       <= top_q.value;
              out_popped_valid_q <= 1'b1;
              out_ovf_q          <= 1'b0;
              out_valid_q        <= 1'b0;
              state_q            <= ST_POP;
            end
          end else if (m_axis_tready_i) begin
            out_valid_q <= 1'b0;
          end
        end
        ST_POP: begin
          if (empty) begin
            out_min_q   <= mts_pkg::MAX_VAL;
            out_empty_q <= 1'b1;
          end else begin
            top_q       <= rd_entry;
            out_min_q   <= rd_entry.min_val;
            out_empty_q <= 1'b0;
          end
          out_valid_q <= 1'b1;
          state_q     <= ST_IDLE;
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_popped_valid_q;
  assign m_axis_tdata_o  = {6'd0, out_ovf_q, out_empty_q, out_min_q, out_popped_q};

endmodule
